[rtl/core/convex_hull_graham_scan_macros.svh]
// assertion macros for the convex hull block
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH
`define CONVEX_HULL_GRAHAM_SCAN_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("convex hull assertion failed");

// next-cycle implication, checked out of reset
`define CHG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("convex hull assertion failed");

`endif

[rtl/core/chg_pkg.sv]
// shared types for the convex hull block
// used by the stream interfaces and the top level; no dependencies
package chg_pkg;

  localparam int FIELD_W = 16;

  typedef logic signed [FIELD_W-1:0] coord_t;

  // status reported on every hull vertex
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_DEGEN   = 2'd2
  } status_t;

endpackage

[rtl/core/chg_point_if.sv]
// input point stream: valid/ready handshake plus one point per transfer
// depends on chg_pkg
interface chg_point_if import chg_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

[rtl/core/chg_hull_if.sv]
// hull vertex stream: valid/ready handshake plus one vertex per transfer
// depends on chg_pkg
interface chg_hull_if import chg_pkg::*;;
  logic    valid;
  logic    ready;
  coord_t  hull_x;
  coord_t  hull_y;
  logic    last_vertex;
  status_t status;

  modport source (output valid, hull_x, hull_y, last_vertex, status, input ready);
  modport sink (input valid, hull_x, hull_y, last_vertex, status, output ready);
endinterface

[rtl/core/convex_hull_graham_scan.sv]
// convex hull of a loaded point set, emitted from the last angle down to the pivot
// depends on chg_pkg, chg_point_if, chg_hull_if, chg_ram and the assertion macros
//
//   channel  dir  payload                                   last marker
//   pts      in   point_x, point_y                          last_point
//   hull     out  hull_x, hull_y, status                    last_vertex
//
// points load at one per cycle into the point ram; the last point starts the hull
// pivot search reads every point once, then each wrapping pass steps over all n points in turn,
// serialised by the one shared multiplier (four products per point) and the single ram read port
// input is not ready from the last point until the pivot vertex transfers out
// rst is synchronous and returns the block to loading with an empty point set
`include "convex_hull_graham_scan_macros.svh"

module convex_hull_graham_scan import chg_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  chg_point_if.sink  pts,
  chg_hull_if.source hull
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int C  = COORD_BITS;
  localparam int MW = 2 * C + 2;
  localparam int TW = 2 * C + 3;

  typedef enum logic [3:0] {
    S_LOAD, S_RD, S_DIFF, S_M1, S_M2, S_M3, S_M4, S_M5, S_DEC, S_SETUP, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PASS_PIVOT, PASS_FIRST, PASS_CHECK, PASS_NEXT
  } pass_t;

  state_t state;
  pass_t  mode;

  logic [CW-1:0] count;
  logic          overflow;
  logic [CW-1:0] idx;
  logic          degen;

  logic signed [C-1:0]  piv_x, piv_y, cur_x, cur_y, cand_x, cand_y, r_x, r_y;
  logic signed [TW-1:0] cand_dist, acc, prod, turn_v, dist_v;
  logic signed [C:0]    da, db, dd, df;

  logic                 we;
  logic [2*C-1:0]       wdata, rdata;
  logic signed [C-1:0]  rd_x, rd_y, in_x, in_y, e_x, e_y;
  logic signed [C:0]    mul_a, mul_b;
  logic signed [MW-1:0] mul_out;
  logic                 pass_end, cur_is_piv, cand_is_piv, cand_take;

  // input coordinates zero-extended or cut to COORD_BITS and taken as COORD_BITS two's complement
  assign in_x  = C'({16'b0, pts.point_x});
  assign in_y  = C'({16'b0, pts.point_y});
  assign we    = (state == S_LOAD) && pts.valid && (count < CW'(MAX_POINTS));
  assign wdata = {in_x, in_y};

  chg_ram #(.WIDTH(2 * C), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (wdata),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_x = rdata[2*C-1:C];
  assign rd_y = rdata[C-1:0];

  // reference end of the turn test: the candidate, or the pivot when checking collinearity
  assign e_x = (mode == PASS_CHECK) ? piv_x : cand_x;
  assign e_y = (mode == PASS_CHECK) ? piv_y : cand_y;

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_M2:    begin mul_a = dd; mul_b = df; end
      S_M3:    begin mul_a = df; mul_b = df; end
      S_M4:    begin mul_a = db; mul_b = db; end
      default: begin mul_a = da; mul_b = db; end
    endcase
  end
  assign mul_out = MW'(mul_a) * MW'(mul_b);

  assign pass_end    = (CW'(idx + CW'(1)) == count);
  assign cur_is_piv  = (cur_x == piv_x) && (cur_y == piv_y);
  assign cand_is_piv = (cand_x == piv_x) && (cand_y == piv_y);
  assign cand_take   = (turn_v < 0) || ((turn_v == 0) && (dist_v > cand_dist));

  // handshakes and output payload
  assign pts.ready        = (state == S_LOAD);
  assign hull.valid       = (state == S_EMIT);
  assign hull.hull_x      = 16'(32'(cur_x));
  assign hull.hull_y      = 16'(32'(cur_y));
  assign hull.last_vertex = cur_is_piv;
  assign hull.status      = degen ? STATUS_DEGEN : (overflow ? STATUS_DROPPED : STATUS_OK);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      mode     <= PASS_PIVOT;
      count    <= '0;
      overflow <= 1'b0;
      idx      <= '0;
      degen    <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (pts.valid) begin
            if (count < CW'(MAX_POINTS)) begin
              count <= count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (pts.last_point) begin
              mode  <= PASS_PIVOT;
              idx   <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          r_x <= rd_x;
          r_y <= rd_y;
          da  <= (C+1)'(cur_x) - (C+1)'(e_x);
          db  <= (C+1)'(rd_y) - (C+1)'(cur_y);
          dd  <= (C+1)'(cur_y) - (C+1)'(e_y);
          df  <= (C+1)'(rd_x) - (C+1)'(cur_x);
          if (mode == PASS_PIVOT) begin
            // greatest y wins, smaller x breaks ties
            if ((idx == '0) || (rd_y > piv_y) || ((rd_y == piv_y) && (rd_x < piv_x))) begin
              piv_x <= rd_x;
              piv_y <= rd_y;
            end
            if (pass_end) begin
              state <= S_SETUP;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_RD;
            end
          end else begin
            state <= S_M1;
          end
        end
        S_M1: begin
          prod  <= TW'(mul_out);
          state <= S_M2;
        end
        S_M2: begin
          prod  <= TW'(mul_out);
          acc   <= prod;
          state <= S_M3;
        end
        S_M3: begin
          prod   <= TW'(mul_out);
          turn_v <= acc - prod;
          state  <= S_M4;
        end
        S_M4: begin
          prod  <= TW'(mul_out);
          acc   <= prod;
          state <= S_M5;
        end
        S_M5: begin
          dist_v <= acc + prod;
          state  <= S_DEC;
        end
        S_DEC: begin
          if (mode == PASS_CHECK) begin
            if (turn_v != 0) begin
              degen <= 1'b0;
            end
          end else if (cand_take) begin
            cand_x    <= r_x;
            cand_y    <= r_y;
            cand_dist <= dist_v;
          end
          if (pass_end) begin
            state <= S_SETUP;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_RD;
          end
        end
        S_SETUP: begin
          idx <= '0;
          case (mode)
            PASS_PIVOT: begin
              cur_x     <= piv_x;
              cur_y     <= piv_y;
              cand_x    <= piv_x;
              cand_y    <= piv_y;
              cand_dist <= '0;
              mode      <= PASS_FIRST;
              state     <= S_RD;
            end
            PASS_FIRST: begin
              cur_x <= cand_x;
              cur_y <= cand_y;
              degen <= 1'b1;
              if (cand_is_piv) begin
                state <= S_EMIT;
              end else begin
                mode  <= PASS_CHECK;
                state <= S_RD;
              end
            end
            default: begin
              cur_x <= cand_x;
              cur_y <= cand_y;
              state <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (hull.ready) begin
            if (cur_is_piv) begin
              count    <= '0;
              overflow <= 1'b0;
              degen    <= 1'b0;
              state    <= S_LOAD;
            end else begin
              cand_x    <= cur_x;
              cand_y    <= cur_y;
              cand_dist <= '0;
              mode      <= PASS_NEXT;
              idx       <= '0;
              state     <= S_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `CHG_ASSERT_IMP(a_count_bound, 1'b1, count <= CW'(MAX_POINTS))
  `CHG_ASSERT_IMP(a_idx_in_set, state == S_DIFF, idx < count)
  `CHG_ASSERT_IMP(a_no_overlap, hull.valid, !pts.ready)
  `CHG_ASSERT_NXT(a_clear_after, hull.valid && hull.ready && hull.last_vertex, count == '0 && !overflow)

endmodule

[rtl/core/chg_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module chg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
